FILE: rtl/aidpd_pkg.sv
// Shared types, register indexes and reset values for the alarm input debounce pattern driver.
package aidpd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 12;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_DEBOUNCE_TICKS = 3'd0;
    localparam cfg_index_t REG_STARTUP_TICKS  = 3'd1;
    localparam cfg_index_t REG_PULSE_ON_TICKS = 3'd2;
    localparam cfg_index_t REG_GAP_TICKS      = 3'd3;
    localparam cfg_index_t REG_LONG_ON_TICKS  = 3'd4;
    localparam cfg_index_t REG_SHORT_PULSES   = 3'd5;
    localparam cfg_index_t REG_ALARM_TICKS    = 3'd6;

    localparam logic [3:0]  DEBOUNCE_TICKS_RST = 4'd10;
    localparam logic [5:0]  STARTUP_TICKS_RST  = 6'd20;
    localparam logic [9:0]  PULSE_ON_TICKS_RST = 10'd100;
    localparam logic [9:0]  GAP_TICKS_RST      = 10'd100;
    localparam logic [9:0]  LONG_ON_TICKS_RST  = 10'd500;
    localparam logic [3:0]  SHORT_PULSES_RST   = 4'd7;
    localparam logic [11:0] ALARM_TICKS_RST    = 12'd1000;

    typedef enum logic [1:0] {
        MODE_WAIT_PRESS        = 2'd0,
        MODE_WAIT_RELEASE      = 2'd1,
        MODE_RUNNING           = 2'd2,
        MODE_WAIT_STOP_RELEASE = 2'd3
    } seq_mode_t;

endpackage

FILE: rtl/alarm_input_debounce_pattern_driver.sv
// Top level: two-input debouncer, toggled pulse pattern, one-shot alarm and follower output.
//
//   channel   signals                                         direction
//   -------   ---------------------------------------------   ---------
//   in        in_valid, in_ready, raw_first, raw_second       request in
//   out       out_valid, out_ready, pattern_out,              result out
//             oneshot_out, follow_out
//   cfg       cfg_write, cfg_index, cfg_data                  write only
//
// Each accepted request is one tick: the whole state update is one pass of logic into the
// state registers, which also drive the result ports. A new request is taken
// every cycle while the result slot is empty or being drained.
// Reset loads the register defaults and resets all state; no clearing pass.
// A stalled result holds in_ready low only when out_ready is low.
module alarm_input_debounce_pattern_driver
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         raw_first,
    input  logic                         raw_second,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         pattern_out,
    output logic                         oneshot_out,
    output logic                         follow_out,
    input  logic                         cfg_write,
    input  aidpd_pkg::cfg_index_t        cfg_index,
    input  logic [aidpd_pkg::CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [3:0]  debounce_ticks_reg;
    logic [5:0]  startup_ticks_reg;
    logic [9:0]  pulse_on_ticks_reg;
    logic [9:0]  gap_ticks_reg;
    logic [9:0]  long_on_ticks_reg;
    logic [3:0]  short_pulses_reg;
    logic [11:0] alarm_ticks_reg;

    // state
    logic [5:0]  startup_count_reg,  startup_count_next;
    logic [1:0]  clean_level_reg,    clean_level_next;
    logic [3:0]  high_run_reg [2];
    logic [3:0]  high_run_next [2];
    logic [3:0]  low_run_reg [2];
    logic [3:0]  low_run_next [2];
    aidpd_pkg::seq_mode_t seq_mode_reg, seq_mode_next;
    logic        phase_is_high_reg,  phase_is_high_next;
    logic [9:0]  phase_count_reg,    phase_count_next;
    logic [3:0]  pulse_index_reg,    pulse_index_next;
    logic        pattern_level_reg,  pattern_level_next;
    logic        oneshot_armed_reg,  oneshot_armed_next;
    logic        oneshot_active_reg, oneshot_active_next;
    logic [11:0] oneshot_count_reg,  oneshot_count_next;
    logic        follow_level_reg,   follow_level_next;
    logic        out_valid_reg;

    logic        accept;
    logic [1:0]  raw;
    logic [3:0]  run_inc;
    logic [9:0]  phase_inc;
    logic [9:0]  on_len;
    logic [11:0] oneshot_inc;
    logic        handling;

    assign in_ready    = !out_valid_reg || out_ready;
    assign accept      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign pattern_out = pattern_level_reg;
    assign oneshot_out = oneshot_active_reg;
    assign follow_out  = follow_level_reg;
    assign raw         = {raw_second, raw_first};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= aidpd_pkg::DEBOUNCE_TICKS_RST;
            startup_ticks_reg  <= aidpd_pkg::STARTUP_TICKS_RST;
            pulse_on_ticks_reg <= aidpd_pkg::PULSE_ON_TICKS_RST;
            gap_ticks_reg      <= aidpd_pkg::GAP_TICKS_RST;
            long_on_ticks_reg  <= aidpd_pkg::LONG_ON_TICKS_RST;
            short_pulses_reg   <= aidpd_pkg::SHORT_PULSES_RST;
            alarm_ticks_reg    <= aidpd_pkg::ALARM_TICKS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                aidpd_pkg::REG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data[3:0];
                aidpd_pkg::REG_STARTUP_TICKS:  startup_ticks_reg  <= cfg_data[5:0];
                aidpd_pkg::REG_PULSE_ON_TICKS: pulse_on_ticks_reg <= cfg_data[9:0];
                aidpd_pkg::REG_GAP_TICKS:      gap_ticks_reg      <= cfg_data[9:0];
                aidpd_pkg::REG_LONG_ON_TICKS:  long_on_ticks_reg  <= cfg_data[9:0];
                aidpd_pkg::REG_SHORT_PULSES:   short_pulses_reg   <= cfg_data[3:0];
                aidpd_pkg::REG_ALARM_TICKS:    alarm_ticks_reg    <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        startup_count_next  = startup_count_reg;
        clean_level_next    = clean_level_reg;
        seq_mode_next       = seq_mode_reg;
        phase_is_high_next  = phase_is_high_reg;
        phase_count_next    = phase_count_reg;
        pulse_index_next    = pulse_index_reg;
        pattern_level_next  = pattern_level_reg;
        oneshot_armed_next  = oneshot_armed_reg;
        oneshot_active_next = oneshot_active_reg;
        oneshot_count_next  = oneshot_count_reg;
        follow_level_next   = follow_level_reg;
        run_inc             = 4'd0;
        oneshot_inc         = 12'd0;

        // debounce both inputs; counters wrap at 4 bits
        for (int ch = 0; ch < 2; ch++)
        begin
            if (raw[ch])
            begin
                low_run_next[ch] = 4'd0;
                run_inc          = high_run_reg[ch] + 4'd1;
                high_run_next[ch] = run_inc;
                if (run_inc == debounce_ticks_reg)
                begin
                    clean_level_next[ch] = 1'b1;
                    high_run_next[ch]    = 4'd0;
                end
            end
            else
            begin
                high_run_next[ch] = 4'd0;
                run_inc           = low_run_reg[ch] + 4'd1;
                low_run_next[ch]  = run_inc;
                if (run_inc == debounce_ticks_reg)
                begin
                    clean_level_next[ch] = 1'b0;
                    low_run_next[ch]     = 4'd0;
                end
            end
        end

        handling  = startup_count_reg >= startup_ticks_reg;
        on_len    = (pulse_index_reg < short_pulses_reg) ? pulse_on_ticks_reg
                                                          : long_on_ticks_reg;
        phase_inc = phase_count_reg + 10'd1;

        if (!handling)
        begin
            startup_count_next = startup_count_reg + 6'd1;
        end
        else
        begin
            case (seq_mode_reg)
                aidpd_pkg::MODE_WAIT_PRESS:
                begin
                    if (!clean_level_next[0])
                        seq_mode_next = aidpd_pkg::MODE_WAIT_RELEASE;
                end
                aidpd_pkg::MODE_WAIT_RELEASE:
                begin
                    if (clean_level_next[0])
                    begin
                        seq_mode_next      = aidpd_pkg::MODE_RUNNING;
                        phase_count_next   = 10'd0;
                        pulse_index_next   = 4'd0;
                        phase_is_high_next = 1'b1;
                    end
                end
                aidpd_pkg::MODE_RUNNING:
                begin
                    phase_count_next = phase_inc;
                    if (phase_is_high_reg)
                    begin
                        pattern_level_next = 1'b1;
                        if (phase_inc == on_len)
                        begin
                            phase_count_next   = 10'd0;
                            pattern_level_next = 1'b0;
                            phase_is_high_next = 1'b0;
                        end
                    end
                    else
                    begin
                        pattern_level_next = 1'b0;
                        if (phase_inc == gap_ticks_reg)
                        begin
                            phase_count_next   = 10'd0;
                            pattern_level_next = 1'b1;
                            phase_is_high_next = 1'b1;
                            // past the short pulses: wrap back to the first
                            pulse_index_next   = (pulse_index_reg < short_pulses_reg)
                                                 ? pulse_index_reg + 4'd1 : 4'd0;
                        end
                    end
                    // a new press stops the pattern
                    if (!clean_level_next[0])
                    begin
                        seq_mode_next      = aidpd_pkg::MODE_WAIT_STOP_RELEASE;
                        phase_count_next   = 10'd0;
                        pulse_index_next   = 4'd0;
                        phase_is_high_next = 1'b1;
                        pattern_level_next = 1'b0;
                    end
                end
                aidpd_pkg::MODE_WAIT_STOP_RELEASE:
                begin
                    if (clean_level_next[0])
                    begin
                        seq_mode_next      = aidpd_pkg::MODE_WAIT_PRESS;
                        phase_count_next   = 10'd0;
                        pulse_index_next   = 4'd0;
                        phase_is_high_next = 1'b1;
                        pattern_level_next = 1'b0;
                    end
                end
                default: ;
            endcase

            // one-shot on input two
            if (oneshot_armed_reg && !clean_level_next[1])
                oneshot_active_next = 1'b1;
            if (oneshot_active_next)
            begin
                oneshot_inc        = oneshot_count_reg + 12'd1;
                oneshot_count_next = oneshot_inc;
                if (oneshot_inc == alarm_ticks_reg)
                begin
                    oneshot_count_next  = 12'd0;
                    oneshot_active_next = 1'b0;
                    oneshot_armed_next  = 1'b0;
                end
            end
            follow_level_next = !clean_level_next[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            startup_count_reg  <= 6'd0;
            clean_level_reg    <= 2'b00;
            high_run_reg[0]    <= 4'd0;
            high_run_reg[1]    <= 4'd0;
            low_run_reg[0]     <= 4'd0;
            low_run_reg[1]     <= 4'd0;
            seq_mode_reg       <= aidpd_pkg::MODE_WAIT_PRESS;
            phase_is_high_reg  <= 1'b1;
            phase_count_reg    <= 10'd0;
            pulse_index_reg    <= 4'd0;
            pattern_level_reg  <= 1'b0;
            oneshot_armed_reg  <= 1'b1;
            oneshot_active_reg <= 1'b0;
            oneshot_count_reg  <= 12'd0;
            follow_level_reg   <= 1'b0;
        end
        else if (accept)
        begin
            startup_count_reg  <= startup_count_next;
            clean_level_reg    <= clean_level_next;
            high_run_reg[0]    <= high_run_next[0];
            high_run_reg[1]    <= high_run_next[1];
            low_run_reg[0]     <= low_run_next[0];
            low_run_reg[1]     <= low_run_next[1];
            seq_mode_reg       <= seq_mode_next;
            phase_is_high_reg  <= phase_is_high_next;
            phase_count_reg    <= phase_count_next;
            pulse_index_reg    <= pulse_index_next;
            pattern_level_reg  <= pattern_level_next;
            oneshot_armed_reg  <= oneshot_armed_next;
            oneshot_active_reg <= oneshot_active_next;
            oneshot_count_reg  <= oneshot_count_next;
            follow_level_reg   <= follow_level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // the pattern is only ever high while running
    a_pattern_only_running: assert property (@(posedge clk) disable iff (!rst_n)
        pattern_level_reg |-> (seq_mode_reg == aidpd_pkg::MODE_RUNNING))
        else $error("pattern output high outside running mode");

    // the one-shot fires only while still armed
    a_oneshot_armed: assert property (@(posedge clk) disable iff (!rst_n)
        oneshot_active_reg |-> oneshot_armed_reg)
        else $error("one-shot active after it was disarmed");

    // once disarmed, the one-shot never rearms without reset
    a_oneshot_stays_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
        !oneshot_armed_reg |=> !oneshot_armed_reg)
        else $error("one-shot rearmed");

    // state and results only move on an accepted request
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(seq_mode_reg) && $stable(startup_count_reg)
                    && $stable(oneshot_count_reg))
        else $error("state changed without a request");

endmodule
